@@ hdl/tor_pkg.sv @@
// Shared types and byte codes for the telnet option refuser.
// No dependencies; the top level, tor_parser and tor_emitter import this package.
package tor_pkg;

  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_DONT = 8'd254;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_SE   = 8'd240;

  // Output channel codes
  localparam logic CHAN_APP   = 1'b0;
  localparam logic CHAN_REPLY = 1'b1;

  // Reply sequence positions
  localparam logic [1:0] SEQ_IAC  = 2'd0;
  localparam logic [1:0] SEQ_VERB = 2'd1;
  localparam logic [1:0] SEQ_OPT  = 2'd2;

  typedef enum logic [4:0] {
    PH_DATA    = 5'b00001,
    PH_CMD     = 5'b00010,
    PH_OPT     = 5'b00100,
    PH_SUB     = 5'b01000,
    PH_SUB_IAC = 5'b10000
  } phase_t;

  // What the parser hands to the emitter for one input byte
  typedef struct packed {
    logic       valid;     // byte produces at least one result
    logic       reply;     // three-byte refusal instead of one data byte
    logic       asked_do;  // refusal verb: WONT if set, DONT otherwise
    logic [7:0] data;      // data byte or option byte
  } run_t;

endpackage

@@ hdl/telnet_option_refuser.sv @@
// The first result is on the output in the cycle after its input transfer; a
// plain byte gives one output transfer, an option refusal three (one per cycle
// while out_stall is low). Throughput: one input byte per cycle while the single
// result register feeding the output port is free or frees on its last take.
// Reset (rst, synchronous): parse returns to the data phase, results drop.
module telnet_option_refuser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       chunk_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       channel,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import tor_pkg::*;

  run_t run;
  logic free;
  logic accept;

  // chunk_end marks software chunk boundaries only; parsing ignores it.

  // Hold the input while the result register still has transfers pending
  // beyond the current cycle; a last result being taken frees it at once.
  assign in_stall = !free;
  assign accept   = in_valid && free;

  // Advance the parse phase and decide what this byte emits
  tor_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .run       (run)
  );

  // Play the run out on the output channel
  tor_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .run         (run),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .channel     (channel),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .free        (free)
  );

endmodule

@@ hdl/tor_parser.sv @@
// Telnet receive parse state: phase and pending DO/DONT flag.
// Depends on tor_pkg; feeds a run_t to tor_emitter.
module tor_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  output tor_pkg::run_t run
);
  import tor_pkg::*;

  phase_t phase;
  phase_t phase_next;
  logic   peer_asked_do;
  logic   peer_asked_do_next;

  always_comb begin
    phase_next         = phase;
    peer_asked_do_next = peer_asked_do;
    run                = '0;
    run.data           = data_byte;
    run.asked_do       = peer_asked_do;
    unique case (phase)
      PH_CMD: begin
        priority if (data_byte == CODE_IAC) begin
          run.valid  = 1'b1;
          phase_next = PH_DATA;
        end else if (data_byte == CODE_WILL || data_byte == CODE_WONT ||
                     data_byte == CODE_DO   || data_byte == CODE_DONT) begin
          peer_asked_do_next = (data_byte == CODE_DO || data_byte == CODE_DONT);
          phase_next         = PH_OPT;
        end else if (data_byte == CODE_SB) begin
          phase_next = PH_SUB;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_OPT: begin
        run.valid  = 1'b1;
        run.reply  = 1'b1;
        phase_next = PH_DATA;
      end
      PH_SUB: begin
        if (data_byte == CODE_IAC) begin
          phase_next = PH_SUB_IAC;
        end
      end
      PH_SUB_IAC: begin
        phase_next = (data_byte == CODE_SE) ? PH_DATA : PH_SUB;
      end
      default: begin
        if (data_byte == CODE_IAC) begin
          phase_next = PH_CMD;
        end else begin
          run.valid  = 1'b1;
          phase_next = PH_DATA;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DATA;
      peer_asked_do <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      peer_asked_do <= peer_asked_do_next;
    end
  end

endmodule

@@ hdl/tor_emitter.sv @@
// Result register that plays out one parsed run as one or three transfers.
// Depends on tor_pkg.
module tor_emitter (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  tor_pkg::run_t run,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          channel,
  output logic [7:0]    out_byte,
  output logic          last_of_run,
  output logic          free
);
  import tor_pkg::*;

  logic       busy;
  logic       reply;
  logic       asked_do;
  logic [7:0] data;
  logic [1:0] seq;
  logic       take;

  assign take        = busy && !out_stall;
  assign out_valid   = busy;
  assign channel     = reply ? CHAN_REPLY : CHAN_APP;
  assign last_of_run = !reply || (seq == SEQ_OPT);
  assign free        = !busy || (take && last_of_run);

  always_comb begin
    out_byte = data;
    if (reply) begin
      unique case (seq)
        SEQ_IAC:  out_byte = CODE_IAC;
        SEQ_VERB: out_byte = asked_do ? CODE_WONT : CODE_DONT;
        default:  out_byte = data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      seq  <= SEQ_IAC;
    end else if (load && run.valid) begin
      busy <= 1'b1;
      seq  <= SEQ_IAC;
    end else if (take && last_of_run) begin
      busy <= 1'b0;
    end else if (take) begin
      seq <= seq + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && run.valid) begin
      reply    <= run.reply;
      asked_do <= run.asked_do;
      data     <= run.data;
    end
  end

endmodule

@@ hdl/tor_checker.sv @@
// Port-level checks for telnet_option_refuser, bound to the top level.
// Depends only on the top-level ports.
module tor_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       channel,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // Input is held back only while results are waiting
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // An application byte is always a run of one
  a_app_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !channel) |-> last_of_run)
    else $error("application byte not marked last");

  // A refusal keeps going on the reply channel until its last byte
  a_reply_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && channel && !last_of_run) |=> (out_valid && channel))
    else $error("reply sequence broken");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(channel)))
    else $error("stalled result changed");

endmodule

bind telnet_option_refuser tor_checker u_tor_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .channel     (channel),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);
